// File: design/mmdp_pkg.sv
// ----------------------------------------------------------------------------
// mmdp_pkg
// Shared types and constants for the min/max decimation pyramid.
// ----------------------------------------------------------------------------
package mmdp_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned FACTOR_W   = 8;
  localparam int unsigned LVL_USED_W = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned LEVEL_W    = 3;

  localparam int unsigned LEVELS_DEF = 8;
  localparam int unsigned MAX_OUT    = 8;

  localparam logic [FACTOR_W-1:0]   BASE_FACTOR_RST  = 8'd5;
  localparam logic [FACTOR_W-1:0]   LEVEL_FACTOR_RST = 8'd5;
  localparam logic [LVL_USED_W-1:0] LEVELS_USED_RST  = 4'd8;

  localparam logic [FACTOR_W-1:0] CNT_SAT = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_FACTOR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVELS_USED  = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t SAMPLE_POS_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_NEG_MAX = 16'sh8000;

  // min/max pair handed from one level to the next
  typedef struct packed {
    logic    have;
    sample_t mn;
    sample_t mx;
  } link_t;

  typedef struct packed {
    sample_t mn;
    sample_t mx;
  } pkt_t;

  typedef struct packed {
    sample_t             mn;
    sample_t             mx;
    logic [FACTOR_W-1:0] cnt;
  } lvl_state_t;

  localparam lvl_state_t LVL_CLEAR = '{mn: SAMPLE_POS_MAX, mx: SAMPLE_NEG_MAX, cnt: '0};

endpackage

// File: design/mmdp_level.sv
// ----------------------------------------------------------------------------
// mmdp_level
// One pyramid level: folds an incoming min/max pair into the running group
// and decides whether the group completes (or flushes at end of stream).
// ----------------------------------------------------------------------------
module mmdp_level (
  input  mmdp_pkg::link_t                      link_i,
  input  mmdp_pkg::lvl_state_t                 state_i,
  input  logic [mmdp_pkg::FACTOR_W-1:0]        factor_i,
  input  logic                                 active_i,
  input  logic                                 eos_i,
  output mmdp_pkg::link_t                      link_o,
  output mmdp_pkg::lvl_state_t                 state_o
);
  import mmdp_pkg::*;

  lvl_state_t upd;
  logic       emit;

  always_comb begin
    upd  = state_i;
    emit = 1'b0;
    if (link_i.have) begin
      if (link_i.mn < state_i.mn) upd.mn = link_i.mn;
      if (link_i.mx > state_i.mx) upd.mx = link_i.mx;
      if (state_i.cnt < CNT_SAT) upd.cnt = state_i.cnt + 8'd1;
      emit = (upd.cnt >= factor_i);
    end
    if (eos_i && (upd.cnt != '0)) emit = 1'b1;

    if (!active_i) begin
      link_o  = '{have: 1'b0, mn: upd.mn, mx: upd.mx};
      state_o = state_i;
    end else begin
      link_o  = '{have: emit, mn: upd.mn, mx: upd.mx};
      state_o = emit ? LVL_CLEAR : upd;
    end
  end

endmodule

// File: design/mmdp_out.sv
// ----------------------------------------------------------------------------
// mmdp_out
// Result register: holds the packets one item produced and hands them out
// one transfer per cycle while the receiver is ready, lowest level first.
// ----------------------------------------------------------------------------
module mmdp_out #(
  parameter int unsigned LEVELS = mmdp_pkg::LEVELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic [LEVELS-1:0]                   mask_i,
  input  mmdp_pkg::pkt_t [LEVELS-1:0]         pkts_i,
  output logic                                free_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mmdp_pkg::LEVEL_W-1:0]        level_o,
  output logic signed [mmdp_pkg::SAMPLE_W-1:0] pkt_min_o,
  output logic signed [mmdp_pkg::SAMPLE_W-1:0] pkt_max_o,
  output logic                                last_of_run_o
);
  import mmdp_pkg::*;

  localparam int unsigned IdxW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  logic [LEVELS-1:0] mask_q, mask_d, rest;
  pkt_t [LEVELS-1:0] pkts_q;
  logic [IdxW-1:0]   sel;
  logic              pop;

  always_comb begin
    sel = '0;
    for (int k = LEVELS - 1; k >= 0; k--) begin
      if (mask_q[k]) sel = IdxW'(k);
    end
  end

  always_comb begin
    rest      = mask_q;
    rest[sel] = 1'b0;
  end

  assign out_valid_o   = |mask_q;
  assign pop           = out_valid_o && out_ready_i;
  assign last_of_run_o = (rest == '0);
  assign free_o        = !out_valid_o || (pop && last_of_run_o);
  assign level_o       = LEVEL_W'(sel);
  assign pkt_min_o     = pkts_q[sel].mn;
  assign pkt_max_o     = pkts_q[sel].mx;

  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      mask_d = mask_i;
    end else if (pop) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pkts_q <= pkts_i;
    end
  end

endmodule

// File: design/minmax_decimation_pyramid.sv
// ----------------------------------------------------------------------------
// minmax_decimation_pyramid
// Peak-detect waveform overview for one audio channel: min/max decimation
// over a chain of levels, with flush of partial groups at end of stream.
//
//   channel   direction  signals
//   input     in         in_valid_i / in_ready_o, sample_i, end_of_stream_i
//   result    out        out_valid_o / out_ready_i, level_o, pkt_min_o,
//                        pkt_max_o, last_of_run_o
//   config    in         cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// An item is first held in the input register, then all levels are
// evaluated in one pass and its packets are loaded into the result register.
// One transfer per cycle while the receiver is ready; an item causing k
// packets holds the result register until all k are taken, so input stalls
// while a multi-packet burst drains or while the receiver holds off a transfer.
// Reset clears level state and restores register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module minmax_decimation_pyramid #(
  parameter int unsigned LEVELS = mmdp_pkg::LEVELS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [mmdp_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [mmdp_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [mmdp_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                  end_of_stream_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [mmdp_pkg::LEVEL_W-1:0]          level_o,
  output logic signed [mmdp_pkg::SAMPLE_W-1:0]  pkt_min_o,
  output logic signed [mmdp_pkg::SAMPLE_W-1:0]  pkt_max_o,
  output logic                                  last_of_run_o
);
  import mmdp_pkg::*;

  localparam int unsigned NCap = (LEVELS < MAX_OUT) ? LEVELS : MAX_OUT;
  localparam logic [LVL_USED_W-1:0] NCapV = LVL_USED_W'(NCap);

  logic [FACTOR_W-1:0]   base_factor_q, level_factor_q;
  logic [LVL_USED_W-1:0] levels_used_q, n_act;

  logic    in_vld_q;
  sample_t smp_q;
  logic    eos_q;
  logic    accept, commit, free;

  lvl_state_t [LEVELS-1:0] st_q;
  lvl_state_t [LEVELS-1:0] st_nxt;
  link_t      [LEVELS:0]   link;
  logic       [LEVELS-1:0] mask;
  pkt_t       [LEVELS-1:0] pkts;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_factor_q  <= BASE_FACTOR_RST;
      level_factor_q <= LEVEL_FACTOR_RST;
      levels_used_q  <= LEVELS_USED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BASE_FACTOR:  base_factor_q  <= cfg_data_i;
        REG_LEVEL_FACTOR: level_factor_q <= cfg_data_i;
        REG_LEVELS_USED:  levels_used_q  <= cfg_data_i[LVL_USED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (levels_used_q == '0) begin
      n_act = LVL_USED_W'(1);
    end else if (levels_used_q > NCapV) begin
      n_act = NCapV;
    end else begin
      n_act = levels_used_q;
    end
  end

  // input register
  assign commit     = in_vld_q && free;
  assign in_ready_o = !in_vld_q || free;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (commit) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q <= sample_i;
      eos_q <= end_of_stream_i;
    end
  end

  // level chain
  assign link[0] = '{have: 1'b1, mn: smp_q, mx: smp_q};

  for (genvar g = 0; g < LEVELS; g++) begin : g_lvl
    mmdp_level u_level (
      .link_i   (link[g]),
      .state_i  (st_q[g]),
      .factor_i ((g == 0) ? base_factor_q : level_factor_q),
      .active_i ({1'b0, LVL_USED_W'(g)} < {1'b0, n_act}),
      .eos_i    (eos_q),
      .link_o   (link[g+1]),
      .state_o  (st_nxt[g])
    );
    assign mask[g] = link[g+1].have;
    assign pkts[g] = '{mn: link[g+1].mn, mx: link[g+1].mx};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) st_q[i] <= LVL_CLEAR;
    end else if (commit) begin
      for (int i = 0; i < LEVELS; i++) st_q[i] <= eos_q ? LVL_CLEAR : st_nxt[i];
    end
  end

  mmdp_out #(
    .LEVELS (LEVELS)
  ) u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (commit),
    .mask_i        (mask),
    .pkts_i        (pkts),
    .free_o        (free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .level_o       (level_o),
    .pkt_min_o     (pkt_min_o),
    .pkt_max_o     (pkt_max_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// File: tb/minmax_decimation_pyramid_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// minmax_decimation_pyramid_test
// Self-checking bench for the min/max decimation pyramid. A directed table
// covers sample extremes, degenerate factors, level saturation, a factor
// lowered mid-group and end-of-stream flushes; random runs with random
// register settings and handshake idling follow. Every packet is compared
// with a local model of the pyramid or with a packet given in the table.
// ----------------------------------------------------------------------------
module minmax_decimation_pyramid_test;
  import mmdp_pkg::*;

  localparam int unsigned NUM_LEVELS  = LEVELS_DEF;
  localparam int unsigned SETTLE_CYC  = 12;
  localparam int unsigned TAIL_CYC    = 20;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RUN_ITEMS   = 12;

  typedef struct packed {
    logic [LEVEL_W-1:0] lvl;
    sample_t            mn;
    sample_t            mx;
    logic               last;
  } packet_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    sample_t                 smp;
    logic                    eos;
    bit                      typed;
    packet_t                 pkt;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  sample_t               sample;
  logic                  eos;
  logic                  out_valid;
  logic                  out_ready;
  logic [LEVEL_W-1:0]    level;
  sample_t               pkt_min;
  sample_t               pkt_max;
  logic                  last_of_run;

  // model state
  logic [FACTOR_W-1:0]   base_fac;
  logic [FACTOR_W-1:0]   lvl_fac;
  logic [LVL_USED_W-1:0] lvls_used;
  lvl_state_t            pyr[NUM_LEVELS];
  packet_t               burst[MAX_OUT];
  int                    burst_len;
  packet_t               pkt_q[$];
  packet_t               head;

  int                    fail_cnt;
  int                    send_idle;
  int                    recv_stall;
  int unsigned           cycles;

  minmax_decimation_pyramid i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .sample_i        (sample),
    .end_of_stream_i (eos),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .level_o         (level),
    .pkt_min_o       (pkt_min),
    .pkt_max_o       (pkt_max),
    .last_of_run_o   (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_pyramid();
    foreach (pyr[i]) pyr[i] = LVL_CLEAR;
  endfunction

  // fold one sample through the active levels; packets land in burst[]
  function automatic void fold_sample(sample_t s, logic flush);
    int                  n;
    logic                have;
    logic                emit;
    sample_t             cur_mn;
    sample_t             cur_mx;
    logic [FACTOR_W-1:0] fac;
    n = int'(lvls_used);
    if (n < 1) n = 1;
    if (n > NUM_LEVELS) n = NUM_LEVELS;
    if (n > MAX_OUT) n = MAX_OUT;
    have      = 1'b1;
    cur_mn    = s;
    cur_mx    = s;
    burst_len = 0;
    for (int i = 0; i < n; i++) begin
      fac  = (i == 0) ? base_fac : lvl_fac;
      emit = 1'b0;
      if (have) begin
        if ($signed(cur_mn) < $signed(pyr[i].mn)) pyr[i].mn = cur_mn;
        if ($signed(cur_mx) > $signed(pyr[i].mx)) pyr[i].mx = cur_mx;
        if (pyr[i].cnt < CNT_SAT) pyr[i].cnt = pyr[i].cnt + 1'b1;
        if (pyr[i].cnt >= fac) emit = 1'b1;
      end
      if (!emit && flush && pyr[i].cnt != '0) emit = 1'b1;
      if (emit) begin
        burst[burst_len] = '{lvl: LEVEL_W'(i), mn: pyr[i].mn, mx: pyr[i].mx, last: 1'b0};
        burst_len++;
        cur_mn = pyr[i].mn;
        cur_mx = pyr[i].mx;
        have   = 1'b1;
        pyr[i] = LVL_CLEAR;
      end else begin
        have = 1'b0;
      end
    end
    if (flush) clear_pyramid();
    if (burst_len > 0) burst[burst_len-1].last = 1'b1;
  endfunction

  function automatic stim_row_t item_row(sample_t s, logic flush);
    stim_row_t r;
    r = '{kind: ROW_ITEM, idx: '0, data: '0, smp: s, eos: flush, typed: 1'b0, pkt: '0};
    return r;
  endfunction

  // single level-zero packet known up front
  function automatic stim_row_t seen_row(sample_t s, logic flush, sample_t mn, sample_t mx);
    stim_row_t r;
    r = item_row(s, flush);
    r.typed = 1'b1;
    r.pkt   = '{lvl: '0, mn: mn, mx: mx, last: 1'b1};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r = '{kind: ROW_CFG, idx: idx, data: val, smp: '0, eos: 1'b0, typed: 1'b0, pkt: '0};
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_factor();
    logic [CFG_DATA_W-1:0] f;
    case ($urandom_range(7))
      0:       f = 8'd0;
      1:       f = 8'd1;
      2:       f = 8'd255;
      3:       f = 8'd2;
      default: f = CFG_DATA_W'($urandom_range(3, 8));
    endcase
    return f;
  endfunction

  task automatic send_item(input sample_t s, input logic flush, input bit typed,
                           input packet_t tp);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    sample   <= s;
    eos      <= flush;
    do @(posedge clk); while (!in_ready);
    fold_sample(s, flush);
    if (typed) begin
      pkt_q = {pkt_q, tp};
    end else begin
      for (int i = 0; i < burst_len; i++) pkt_q = {pkt_q, burst[i]};
    end
  endtask

  // drop valid, wait for all packets, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pkt_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    settle();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      REG_BASE_FACTOR:  base_fac  = val;
      REG_LEVEL_FACTOR: lvl_fac   = val;
      REG_LEVELS_USED:  lvls_used = val[LVL_USED_W-1:0];
      default: ;
    endcase
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pkt_q.size() == 0) begin
        $error("packet with no expectation: level %0d min %0d max %0d",
               level, pkt_min, pkt_max);
        fail_cnt++;
      end else begin
        head = pkt_q.pop_front();
        if (level !== head.lvl) begin
          $error("level: expected %0d, got %0d", head.lvl, level);
          fail_cnt++;
        end
        if (pkt_min !== head.mn) begin
          $error("pkt_min: expected %0d, got %0d", $signed(head.mn), pkt_min);
          fail_cnt++;
        end
        if (pkt_max !== head.mx) begin
          $error("pkt_max: expected %0d, got %0d", $signed(head.mx), pkt_max);
          fail_cnt++;
        end
        if (last_of_run !== head.last) begin
          $error("last_of_run: expected %0d, got %0d", head.last, last_of_run);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    stim_row_t tbl[$];
    sample_t   smp;
    logic      flush;
    packet_t   none;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    sample     = '0;
    eos        = 1'b0;
    out_ready  = 1'b0;
    fail_cnt   = 0;
    send_idle  = 0;
    recv_stall = 0;
    none       = '0;
    base_fac   = BASE_FACTOR_RST;
    lvl_fac    = LEVEL_FACTOR_RST;
    lvls_used  = LEVELS_USED_RST;
    clear_pyramid();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: five samples close a level-zero group
    tbl = {tbl, item_row(16'sh7FFF, 1'b0)};
    tbl = {tbl, item_row(16'sh8000, 1'b0)};
    tbl = {tbl, item_row(16'sh0000, 1'b0)};
    tbl = {tbl, item_row(16'sh0001, 1'b0)};
    tbl = {tbl, seen_row(16'shFFFF, 1'b0, SAMPLE_NEG_MAX, SAMPLE_POS_MAX)};
    tbl = {tbl, item_row(16'sh0064, 1'b1)};
    tbl = {tbl, item_row(16'sh0005, 1'b1)};
    // zero base factor, zero levels -> one level, every sample is a packet
    tbl = {tbl, cfg_row(REG_BASE_FACTOR, 8'd0)};
    tbl = {tbl, cfg_row(REG_LEVEL_FACTOR, 8'd1)};
    tbl = {tbl, cfg_row(REG_LEVELS_USED, 8'd0)};
    tbl = {tbl, seen_row(16'sh1234, 1'b0, 16'sh1234, 16'sh1234)};
    tbl = {tbl, seen_row(16'shEDCB, 1'b1, 16'shEDCB, 16'shEDCB)};
    // levels saturate at the top; every level fires on every sample
    tbl = {tbl, cfg_row(REG_LEVELS_USED, 8'hFF)};
    tbl = {tbl, cfg_row(REG_BASE_FACTOR, 8'd1)};
    tbl = {tbl, cfg_row(REG_LEVEL_FACTOR, 8'd0)};
    tbl = {tbl, item_row(16'sh5555, 1'b0)};
    tbl = {tbl, item_row(16'shAAAA, 1'b1)};
    // widest factors: only the flush emits
    tbl = {tbl, cfg_row(REG_BASE_FACTOR, 8'd255)};
    tbl = {tbl, cfg_row(REG_LEVEL_FACTOR, 8'd255)};
    tbl = {tbl, cfg_row(REG_LEVELS_USED, 8'd2)};
    tbl = {tbl, item_row(16'sh4000, 1'b0)};
    tbl = {tbl, item_row(16'shC000, 1'b0)};
    tbl = {tbl, item_row(16'sh7FFE, 1'b1)};
    // factor lowered under a partly filled group
    tbl = {tbl, cfg_row(REG_BASE_FACTOR, 8'd10)};
    tbl = {tbl, cfg_row(REG_LEVELS_USED, 8'd1)};
    tbl = {tbl, item_row(16'sh0100, 1'b0)};
    tbl = {tbl, item_row(16'shFF00, 1'b0)};
    tbl = {tbl, item_row(16'sh0200, 1'b0)};
    tbl = {tbl, item_row(16'shFE00, 1'b0)};
    tbl = {tbl, item_row(16'sh0300, 1'b0)};
    tbl = {tbl, item_row(16'shFD00, 1'b0)};
    tbl = {tbl, item_row(16'sh0400, 1'b0)};
    tbl = {tbl, cfg_row(REG_BASE_FACTOR, 8'd3)};
    tbl = {tbl, seen_row(16'sh0050, 1'b0, 16'shFD00, 16'sh0400)};
    tbl = {tbl, item_row(16'sh0000, 1'b1)};
    tbl = {tbl, cfg_row(REG_LEVELS_USED, 8'd8)};

    foreach (tbl[r]) begin
      if (tbl[r].kind == ROW_CFG) begin
        cfg_write(tbl[r].idx, tbl[r].data);
      end else begin
        send_item(tbl[r].smp, tbl[r].eos, tbl[r].typed, tbl[r].pkt);
      end
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 56; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 56; end
        default: begin send_idle = 15; recv_stall = 15; end
      endcase
      for (int c = 0; c < 2; c++) begin
        cfg_write(REG_BASE_FACTOR, pick_factor());
        cfg_write(REG_LEVEL_FACTOR, pick_factor());
        cfg_write(REG_LEVELS_USED, CFG_DATA_W'($urandom_range(255)));
        for (int k = 0; k < RUN_ITEMS; k++) begin
          if (p == 1 && k == 7) settle();
          case ($urandom_range(7))
            0:       smp = SAMPLE_POS_MAX;
            1:       smp = SAMPLE_NEG_MAX;
            default: smp = sample_t'($urandom);
          endcase
          flush = (k == RUN_ITEMS - 1) || ($urandom_range(9) == 0);
          send_item(smp, flush, 1'b0, none);
        end
      end
    end

    settle();
    repeat (TAIL_CYC) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/mmdp_pkg.sv
design/mmdp_level.sv
design/mmdp_out.sv
design/minmax_decimation_pyramid.sv
tb/minmax_decimation_pyramid_test.sv
